// ===== src/isc_pkg.sv =====
// Shared constants, command types and arithmetic helpers for the increasing subsequence counter.
package isc_pkg;

    localparam int VALUE_RANGE = 1024;
    localparam int ADDR_W      = $clog2(VALUE_RANGE);
    localparam int PTR_W       = ADDR_W + 1;
    localparam int VALUE_W     = 10;
    localparam int MAX_LENGTH  = 16;
    localparam int LEN_IDX_W   = $clog2(MAX_LENGTH);
    localparam int LEN_REG_W   = 5;
    localparam int COUNT_W     = 23;

    localparam logic [COUNT_W-1:0] COUNT_MOD = COUNT_W'(5000000);
    localparam logic [VALUE_W-1:0] VALUE_MAX = VALUE_W'(VALUE_RANGE - 2);

    // Register index on the configuration port
    localparam logic REG_SUBSEQ_LENGTH = 1'b0;

    typedef logic [COUNT_W-1:0] t_count;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_CAPTURE,
        DP_LOAD_QUERY,
        DP_RUN_QUERY,
        DP_LOAD_UPDATE,
        DP_RUN_UPDATE,
        DP_LOAD_TOTAL,
        DP_LOAD_CLEAR,
        DP_RUN_CLEAR
    } t_dp_op;

    typedef struct packed {
        t_dp_op                op;
        logic [LEN_IDX_W-1:0]  len_m1;
    } t_dp_cmd;

    typedef struct packed {
        logic done;
    } t_dp_status;

    function automatic logic [PTR_W-1:0] low_bit(input logic [PTR_W-1:0] x);
        return x & (~x + PTR_W'(1));
    endfunction

    // Operands are both below the modulus, so one conditional subtract suffices
    function automatic t_count mod_add(input t_count a, input t_count b);
        logic [COUNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, COUNT_MOD}) begin
            s = s - {1'b0, COUNT_MOD};
        end
        return s[COUNT_W-1:0];
    endfunction

endpackage

// ===== src/isc_tree_bank.sv =====
// One tree bank: a single-write, single-read memory with registered read data.
module isc_tree_bank
    import isc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output t_count            o_rd_data,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  t_count            i_wr_data
);

    t_count r_mem [VALUE_RANGE];
    t_count r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/isc_datapath.sv =====
// Datapath: tree banks, chain pointer, per-length accumulators and clearing sweep.
module isc_datapath
    import isc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    input  logic [VALUE_W-1:0] i_value,
    output t_dp_status         o_status,
    output t_count             o_total
);

    logic [VALUE_W-1:0] r_value;
    logic [PTR_W-1:0]   r_ptr;
    logic [ADDR_W-1:0]  r_wb_addr;
    logic               r_rd_pend;
    logic               r_wr_pend;
    t_count             r_acc [MAX_LENGTH];

    t_count             rd_data [MAX_LENGTH];
    logic               rd_en;
    logic               clear_wr;
    logic [ADDR_W-1:0]  wr_addr;

    assign rd_en = ((i_cmd.op == DP_RUN_QUERY) && (r_ptr != '0)) ||
                   ((i_cmd.op == DP_RUN_UPDATE) && !r_ptr[PTR_W-1]);
    assign clear_wr = (i_cmd.op == DP_RUN_CLEAR) && !r_ptr[PTR_W-1];
    assign wr_addr  = clear_wr ? r_ptr[ADDR_W-1:0] : r_wb_addr;

    // Capture the item value, saturated to the top of the tree range
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == DP_CAPTURE) begin
            r_value <= (i_value > VALUE_MAX) ? VALUE_MAX : i_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr     <= '0;
            r_rd_pend <= 1'b0;
            r_wr_pend <= 1'b0;
        end else begin
            r_rd_pend <= 1'b0;
            r_wr_pend <= 1'b0;
            unique case (i_cmd.op)
                DP_LOAD_QUERY:  r_ptr <= PTR_W'(r_value);
                DP_LOAD_UPDATE: r_ptr <= PTR_W'(r_value) + PTR_W'(1);
                DP_LOAD_TOTAL:  r_ptr <= PTR_W'(VALUE_RANGE - 1);
                DP_LOAD_CLEAR:  r_ptr <= '0;
                DP_RUN_QUERY: begin
                    if (r_ptr != '0) begin
                        r_ptr     <= r_ptr - low_bit(r_ptr);
                        r_rd_pend <= 1'b1;
                    end
                end
                DP_RUN_UPDATE: begin
                    if (!r_ptr[PTR_W-1]) begin
                        r_ptr     <= r_ptr + low_bit(r_ptr);
                        r_wb_addr <= r_ptr[ADDR_W-1:0];
                        r_wr_pend <= 1'b1;
                    end
                end
                DP_RUN_CLEAR: begin
                    if (!r_ptr[PTR_W-1]) begin
                        r_ptr <= r_ptr + PTR_W'(1);
                    end
                end
                DP_NOP, DP_CAPTURE: ;
                default: ;
            endcase
        end
    end

    for (genvar j = 0; j < MAX_LENGTH; j++) begin : g_bank
        t_count amount;
        logic   wr_en;
        t_count wr_data;

        if (j == 0) begin : g_first
            assign amount = COUNT_W'(1);
        end else begin : g_upper
            assign amount = r_acc[j-1];
        end

        assign wr_en   = clear_wr || (r_wr_pend && (LEN_IDX_W'(j) <= i_cmd.len_m1));
        assign wr_data = clear_wr ? '0 : mod_add(rd_data[j], amount);

        isc_tree_bank u_bank (
            .i_clk     (i_clk),
            .i_rd_en   (rd_en),
            .i_rd_addr (r_ptr[ADDR_W-1:0]),
            .o_rd_data (rd_data[j]),
            .i_wr_en   (wr_en),
            .i_wr_addr (wr_addr),
            .i_wr_data (wr_data)
        );

        // Accumulate the prefix sum of this tree along the query chain
        always_ff @(posedge i_clk) begin
            if ((i_cmd.op == DP_LOAD_QUERY) || (i_cmd.op == DP_LOAD_TOTAL)) begin
                r_acc[j] <= '0;
            end else if (r_rd_pend) begin
                r_acc[j] <= mod_add(r_acc[j], rd_data[j]);
            end
        end
    end

    always_comb begin
        unique case (i_cmd.op)
            DP_RUN_QUERY:  o_status.done = (r_ptr == '0) && !r_rd_pend;
            DP_RUN_UPDATE: o_status.done = r_ptr[PTR_W-1] && !r_wr_pend;
            DP_RUN_CLEAR:  o_status.done = r_ptr[PTR_W-1];
            default:       o_status.done = 1'b0;
        endcase
    end

    assign o_total = r_acc[i_cmd.len_m1];

endmodule

// ===== src/isc_ctrl.sv =====
// Controller: sequences capture, query, update, total, emit and clearing sweep.
module isc_ctrl
    import isc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_last,
    input  logic                 i_out_full,
    input  logic [LEN_IDX_W-1:0] i_len_m1,
    input  t_dp_status           i_status,
    output logic                 o_in_ready,
    output logic                 o_emit,
    output t_dp_cmd              o_cmd
);

    typedef enum logic [3:0] {
        S_CLEAR_LOAD,
        S_CLEAR_RUN,
        S_IDLE,
        S_QRY_LOAD,
        S_QRY_RUN,
        S_UPD_LOAD,
        S_UPD_RUN,
        S_TOT_LOAD,
        S_TOT_RUN,
        S_EMIT
    } t_state;

    t_state r_state;
    logic   r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR_LOAD;
            r_last  <= 1'b0;
        end else begin
            unique case (r_state)
                S_CLEAR_LOAD: r_state <= S_CLEAR_RUN;
                S_CLEAR_RUN: begin
                    if (i_status.done) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_last  <= i_in_last;
                        r_state <= S_QRY_LOAD;
                    end
                end
                S_QRY_LOAD: r_state <= S_QRY_RUN;
                S_QRY_RUN: begin
                    if (i_status.done) r_state <= S_UPD_LOAD;
                end
                S_UPD_LOAD: r_state <= S_UPD_RUN;
                S_UPD_RUN: begin
                    if (i_status.done) r_state <= r_last ? S_TOT_LOAD : S_IDLE;
                end
                S_TOT_LOAD: r_state <= S_TOT_RUN;
                S_TOT_RUN: begin
                    if (i_status.done) r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (!i_out_full) r_state <= S_CLEAR_LOAD;
                end
                default: r_state <= S_CLEAR_LOAD;
            endcase
        end
    end

    always_comb begin
        o_cmd.len_m1 = i_len_m1;
        unique case (r_state)
            S_CLEAR_LOAD: o_cmd.op = DP_LOAD_CLEAR;
            S_CLEAR_RUN:  o_cmd.op = DP_RUN_CLEAR;
            S_IDLE:       o_cmd.op = i_in_valid ? DP_CAPTURE : DP_NOP;
            S_QRY_LOAD:   o_cmd.op = DP_LOAD_QUERY;
            S_QRY_RUN:    o_cmd.op = DP_RUN_QUERY;
            S_UPD_LOAD:   o_cmd.op = DP_LOAD_UPDATE;
            S_UPD_RUN:    o_cmd.op = DP_RUN_UPDATE;
            S_TOT_LOAD:   o_cmd.op = DP_LOAD_TOTAL;
            S_TOT_RUN:    o_cmd.op = DP_RUN_QUERY;
            S_EMIT:       o_cmd.op = DP_NOP;
            default:      o_cmd.op = DP_NOP;
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_emit     = (r_state == S_EMIT) && !i_out_full;

endmodule

// ===== src/increasing_subsequence_counter.sv =====
// Top level: stream ports, APB length register, output item register.
// Flow: an item is taken only while idle; no new item is accepted until the tree reads and
//   tree writes of its Fenwick chains are through. Reads and writes always total 10 (value
//   zero needs no read). The shared tree-bank port walks one node a cycle.
// A last item adds a total walk and an emit state before its count item appears (emit waits
//   while the output register is full), then a clearing sweep over the banks, with no item accepted.
// Reset: synchronous, active low; starts the same clearing sweep; length register -> 1.
module increasing_subsequence_counter
    import isc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [9:0] value, [15:10] zero
    input  logic        s_axis_tlast,   // last
    // result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // [22:0] count, [23] zero
);

    logic [LEN_REG_W-1:0] r_len;
    logic [LEN_IDX_W-1:0] len_m1;
    logic                 r_out_valid;
    t_count               r_out_count;

    t_dp_cmd              cmd;
    t_dp_status           status;
    t_count               total;
    logic                 emit;
    logic                 in_ready;

    // Length register: written on the APB access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= LEN_REG_W'(1);
        end else if (psel && penable && pwrite && (paddr[2] == REG_SUBSEQ_LENGTH)) begin
            r_len <= pwdata[LEN_REG_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_SUBSEQ_LENGTH) ? 32'(r_len) : '0;

    // Clamp the length into 1..MAX_LENGTH, held as length minus one
    always_comb begin
        if (r_len == '0) begin
            len_m1 = '0;
        end else if (r_len > LEN_REG_W'(MAX_LENGTH)) begin
            len_m1 = LEN_IDX_W'(MAX_LENGTH - 1);
        end else begin
            len_m1 = LEN_IDX_W'(r_len - LEN_REG_W'(1));
        end
    end

    isc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_last  (s_axis_tlast),
        .i_out_full (r_out_valid),
        .i_len_m1   (len_m1),
        .i_status   (status),
        .o_in_ready (in_ready),
        .o_emit     (emit),
        .o_cmd      (cmd)
    );

    isc_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_value  (s_axis_tdata[VALUE_W-1:0]),
        .o_status (status),
        .o_total  (total)
    );

    assign s_axis_tready = in_ready;

    // Output item register: load on emit, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_count <= total;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out_count};

endmodule
